[sv/assert_macros.svh]
// Assertion macros shared by the load cell reader RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[sv/lcadc_pkg.sv]
// Shared types and codes for the load cell converter serial reader.
`timescale 1ns / 1ps
package lcadc_pkg;

  // Command codes carried by each tick.
  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_READ  = 3'd1,
    OP_TARE  = 3'd2,
    OP_PDOWN = 3'd3,
    OP_PUP   = 3'd4
  } op_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_GAIN    = 2'd0,
    REG_TIMEOUT = 2'd1,
    REG_OFFSET  = 2'd2,
    REG_SCALE   = 2'd3
  } cfg_reg_t;

  localparam logic [23:0] TIMEOUT_RESET = 24'd1000000;
  localparam logic [31:0] SCALE_RESET   = 32'h0001_0000;
  localparam logic [4:0]  DATA_BITS     = 5'd24;
  localparam logic signed [31:0] WEIGHT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] WEIGHT_MIN = 32'sh8000_0000;

  // One result item.
  typedef struct packed {
    logic               sck_level;
    logic               busy_res;
    logic               read_done;
    logic               tare_done;
    logic               status;
    logic signed [23:0] raw_value;
    logic signed [31:0] weight;
    logic signed [23:0] offset_value;
  } result_t;

endpackage

[sv/lcadc_weight_calc.sv]
// Free-running two-stage weight multiplier with floor shift and saturation.
`timescale 1ns / 1ps
module lcadc_weight_calc (
  input  logic               clk,
  input  logic        [23:0] shift_word,
  input  logic signed [23:0] offset,
  input  logic signed [31:0] inv_scale,
  output logic signed [31:0] weight
);

  logic signed [24:0] diff_r;
  logic signed [24:0] diff_nxt;
  logic signed [56:0] prod_r;
  logic signed [40:0] quo;

  // Subtract the zero offset from the sign-extended sample.
  assign diff_nxt = {shift_word[23], shift_word} - {offset[23], offset};

  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
    prod_r <= diff_r * inv_scale;
  end

  // Arithmetic shift floors; clamp to 32 bits.
  assign quo = prod_r[56:16];

  always_comb begin
    if (quo[40:31] == {10{quo[31]}}) begin
      weight = quo[31:0];
    end else if (quo[40]) begin
      weight = lcadc_pkg::WEIGHT_MIN;
    end else begin
      weight = lcadc_pkg::WEIGHT_MAX;
    end
  end

endmodule

[sv/lcadc_tare_div.sv]
// Free-running tare average: sum plus sample, divided by the sample count.
`timescale 1ns / 1ps
module lcadc_tare_div #(
  parameter int TARE_COUNT = 10
) (
  input  logic                                        clk,
  input  logic [23:0]                                 shift_word,
  input  logic signed [24+$clog2(TARE_COUNT+1)-1:0]   tare_sum,
  output logic signed [23:0]                          quotient
);

  localparam int SUM_W = 24 + $clog2(TARE_COUNT + 1);
  localparam int K     = SUM_W + 4;
  localparam logic [K:0] RECIP = (K + 1)'(((64'd1 << K) + TARE_COUNT - 1) / TARE_COUNT);

  logic signed [SUM_W-1:0] raw_ext;
  logic signed [SUM_W-1:0] total;
  logic        [SUM_W-1:0] mag_nxt;
  logic        [SUM_W-1:0] mag_r;
  logic                    neg_r;
  logic        [SUM_W+K:0] prod_r;
  logic        [23:0]      quo_mag;

  // Final sum and its magnitude.
  assign raw_ext = SUM_W'($signed(shift_word));
  assign total   = tare_sum + raw_ext;
  assign mag_nxt = total[SUM_W-1] ? SUM_W'(-total) : SUM_W'(total);

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    neg_r  <= total[SUM_W-1];
    prod_r <= (SUM_W + K + 1)'(mag_r) * (SUM_W + K + 1)'(RECIP);
  end

  // Reciprocal product floors the magnitude; restore the sign to truncate toward zero.
  assign quo_mag  = prod_r[K +: 24];
  assign quotient = neg_r ? -quo_mag : quo_mag;

endmodule

[sv/lcadc_ctrl.sv]
// Serial clock sequencer, configuration registers and reader state.
`timescale 1ns / 1ps
module lcadc_ctrl #(
  parameter int TARE_COUNT = 10
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      step,
  input  logic [2:0]                                op,
  input  logic                                      dout_level,
  input  logic                                      cfg_we,
  input  logic [1:0]                                cfg_index,
  input  logic [31:0]                               cfg_data,
  input  logic signed [31:0]                        weight_calc,
  input  logic signed [23:0]                        tare_quo,
  output lcadc_pkg::result_t                        res,
  output logic [23:0]                               shift_word,
  output logic signed [24+$clog2(TARE_COUNT+1)-1:0] tare_sum,
  output logic signed [23:0]                        offset,
  output logic signed [31:0]                        inv_scale
);

  localparam int SC_W  = $clog2(TARE_COUNT + 1);
  localparam int SUM_W = 24 + SC_W;

  typedef enum logic [2:0] {
    PH_IDLE, PH_WAIT, PH_HIGH, PH_LOW, PH_PHIGH, PH_PLOW
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [1:0]              gain_r;
  logic [23:0]             timeout_r;
  logic signed [31:0]      scale_r;
  logic                    pd_r, pd_nxt;
  logic                    tare_r, tare_nxt;
  logic [4:0]              bit_r, bit_nxt;
  logic [1:0]              pulse_r, pulse_nxt;
  logic [23:0]             shift_r, shift_nxt;
  logic [23:0]             wait_r, wait_nxt;
  logic [SC_W-1:0]         sample_r, sample_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [23:0]      offset_r, offset_nxt;
  logic signed [23:0]      raw_r, raw_nxt;
  logic signed [31:0]      weight_r, weight_nxt;
  logic                    sck, rdone, tdone, stat;
  logic [1:0]              gain_eff;
  logic [SC_W:0]           sample_inc;

  assign gain_eff   = (gain_r == 2'd0) ? 2'd1 : gain_r;
  assign sample_inc = (SC_W + 1)'(sample_r) + 1'b1;

  // Next state for one tick.
  always_comb begin
    phase_nxt  = phase_r;
    pd_nxt     = pd_r;
    tare_nxt   = tare_r;
    bit_nxt    = bit_r;
    pulse_nxt  = pulse_r;
    shift_nxt  = shift_r;
    wait_nxt   = wait_r;
    sample_nxt = sample_r;
    sum_nxt    = sum_r;
    offset_nxt = offset_r;
    raw_nxt    = raw_r;
    weight_nxt = weight_r;
    sck        = 1'b0;
    rdone      = 1'b0;
    tdone      = 1'b0;
    stat       = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        if ((op == lcadc_pkg::OP_READ || op == lcadc_pkg::OP_TARE) && !pd_r) begin
          tare_nxt   = (op == lcadc_pkg::OP_TARE);
          wait_nxt   = '0;
          sample_nxt = '0;
          sum_nxt    = '0;
          phase_nxt  = PH_WAIT;
        end else if (op == lcadc_pkg::OP_PDOWN) begin
          pd_nxt = 1'b1;
        end else if (op == lcadc_pkg::OP_PUP) begin
          pd_nxt = 1'b0;
        end
        sck = pd_nxt;
      end
      PH_WAIT: begin
        if (!dout_level) begin
          bit_nxt   = '0;
          shift_nxt = '0;
          phase_nxt = PH_HIGH;
          sck       = 1'b1;
        end else if (wait_r >= timeout_r) begin
          stat = 1'b1;
          if (tare_r) begin
            tdone = 1'b1;
          end else begin
            rdone      = 1'b1;
            weight_nxt = '0;
          end
          phase_nxt = PH_IDLE;
        end else begin
          wait_nxt = wait_r + 24'd1;
        end
      end
      PH_HIGH: begin
        shift_nxt = {shift_r[22:0], dout_level};
        bit_nxt   = bit_r + 5'd1;
        phase_nxt = PH_LOW;
      end
      PH_LOW: begin
        if (bit_r < lcadc_pkg::DATA_BITS) begin
          phase_nxt = PH_HIGH;
        end else begin
          pulse_nxt = '0;
          phase_nxt = PH_PHIGH;
        end
        sck = 1'b1;
      end
      PH_PHIGH: begin
        pulse_nxt = pulse_r + 2'd1;
        phase_nxt = PH_PLOW;
      end
      PH_PLOW: begin
        if (pulse_r < gain_eff) begin
          phase_nxt = PH_PHIGH;
          sck       = 1'b1;
        end else begin
          raw_nxt = shift_r;
          if (!tare_r) begin
            weight_nxt = weight_calc;
            rdone      = 1'b1;
            phase_nxt  = PH_IDLE;
          end else begin
            sum_nxt    = sum_r + SUM_W'($signed(shift_r));
            sample_nxt = sample_inc[SC_W-1:0];
            if (sample_inc >= (SC_W + 1)'(TARE_COUNT)) begin
              offset_nxt = tare_quo;
              tdone      = 1'b1;
              phase_nxt  = PH_IDLE;
            end else begin
              wait_nxt  = '0;
              phase_nxt = PH_WAIT;
            end
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Hold state and configuration; advance on each transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      gain_r    <= 2'd1;
      timeout_r <= lcadc_pkg::TIMEOUT_RESET;
      scale_r   <= lcadc_pkg::SCALE_RESET;
      pd_r      <= 1'b0;
      tare_r    <= 1'b0;
      bit_r     <= '0;
      pulse_r   <= '0;
      shift_r   <= '0;
      wait_r    <= '0;
      sample_r  <= '0;
      sum_r     <= '0;
      offset_r  <= '0;
      raw_r     <= '0;
      weight_r  <= '0;
    end else begin
      if (step) begin
        phase_r  <= phase_nxt;
        pd_r     <= pd_nxt;
        tare_r   <= tare_nxt;
        bit_r    <= bit_nxt;
        pulse_r  <= pulse_nxt;
        shift_r  <= shift_nxt;
        wait_r   <= wait_nxt;
        sample_r <= sample_nxt;
        sum_r    <= sum_nxt;
        offset_r <= offset_nxt;
        raw_r    <= raw_nxt;
        weight_r <= weight_nxt;
      end
      if (cfg_we) begin
        unique case (lcadc_pkg::cfg_reg_t'(cfg_index))
          lcadc_pkg::REG_GAIN:    gain_r    <= cfg_data[1:0];
          lcadc_pkg::REG_TIMEOUT: timeout_r <= cfg_data[23:0];
          lcadc_pkg::REG_OFFSET:  offset_r  <= cfg_data[23:0];
          lcadc_pkg::REG_SCALE:   scale_r   <= cfg_data;
        endcase
      end
    end
  end

  // Result of this tick.
  always_comb begin
    res.sck_level    = sck;
    res.busy_res     = (phase_nxt != PH_IDLE);
    res.read_done    = rdone;
    res.tare_done    = tdone;
    res.status       = stat;
    res.raw_value    = raw_nxt;
    res.weight       = weight_nxt;
    res.offset_value = offset_nxt;
  end

  assign shift_word = shift_r;
  assign tare_sum   = sum_r;
  assign offset     = offset_r;
  assign inv_scale  = scale_r;

endmodule

[sv/lcadc_out_skid.sv]
// Output register with a skid stage for the result channel.
`timescale 1ns / 1ps
module lcadc_out_skid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lcadc_pkg::result_t push_data,
  output logic               push_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output lcadc_pkg::result_t out_data
);

  logic               out_valid_r;
  logic               skid_valid_r;
  lcadc_pkg::result_t out_r;
  lcadc_pkg::result_t skid_r;

  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

  // Refill the output from the skid first; park a transfer in the skid while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
        if (push) begin
          out_r <= push_data;
        end
      end
    end else if (push) begin
      skid_r       <= push_data;
      skid_valid_r <= 1'b1;
    end
  end

endmodule

[sv/load_cell_adc_serial_reader_unit.sv]
// Top level of the load cell converter serial reader.
//
// Each input transfer is one half-period tick of the converter's serial clock and yields
// exactly one result transfer; the block takes one tick per clock cycle unless the skid is
// full, and a result is offered on the cycle after its tick is taken when the output is not
// stalled. A two-deep output stage (register plus skid) absorbs one input tick during an
// output stall. The weight product and the tare average come from free-running two-stage
// multiplier pipelines that settle on the stable shift word during the low half and gain
// pulses after the last data bit, so they never stall a tick. Config writes never stall.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module load_cell_adc_serial_reader_unit #(
  parameter int TARE_COUNT = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_op,
  input  logic               in_dout_level,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_sck_level,
  output logic               out_busy_res,
  output logic               out_read_done,
  output logic               out_tare_done,
  output logic               out_status,
  output logic signed [23:0] out_raw_value,
  output logic signed [31:0] out_weight,
  output logic signed [23:0] out_offset_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int SUM_W = 24 + $clog2(TARE_COUNT + 1);

  logic                    step;
  logic                    cfg_we;
  lcadc_pkg::result_t      res;
  lcadc_pkg::result_t      out_data;
  logic [23:0]             shift_word;
  logic signed [SUM_W-1:0] tare_sum;
  logic signed [23:0]      offset;
  logic signed [31:0]      inv_scale;
  logic signed [31:0]      weight_calc;
  logic signed [23:0]      tare_quo;

  assign step      = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid;

  lcadc_ctrl #(
    .TARE_COUNT(TARE_COUNT)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .op         (in_op),
    .dout_level (in_dout_level),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .weight_calc(weight_calc),
    .tare_quo   (tare_quo),
    .res        (res),
    .shift_word (shift_word),
    .tare_sum   (tare_sum),
    .offset     (offset),
    .inv_scale  (inv_scale)
  );

  lcadc_weight_calc u_weight (
    .clk       (clk),
    .shift_word(shift_word),
    .offset    (offset),
    .inv_scale (inv_scale),
    .weight    (weight_calc)
  );

  lcadc_tare_div #(
    .TARE_COUNT(TARE_COUNT)
  ) u_tare (
    .clk       (clk),
    .shift_word(shift_word),
    .tare_sum  (tare_sum),
    .quotient  (tare_quo)
  );

  lcadc_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .push_data (res),
    .push_ready(in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_sck_level    = out_data.sck_level;
  assign out_busy_res     = out_data.busy_res;
  assign out_read_done    = out_data.read_done;
  assign out_tare_done    = out_data.tare_done;
  assign out_status       = out_data.status;
  assign out_raw_value    = out_data.raw_value;
  assign out_weight       = out_data.weight;
  assign out_offset_value = out_data.offset_value;

  // Input backpressure only while a result is waiting.
  `ASSERT_IMPL(a_stall_has_result, clk, rst_n, !in_ready, out_valid, "stall without result")
  // A tick taken with no result pending shows up on the next cycle.
  `ASSERT_NEXT(a_result_follows, clk, rst_n, step && !out_valid, out_valid, "result lost")
  // Read and tare never finish on the same tick.
  `ASSERT_IMPL(a_done_excl, clk, rst_n, out_valid, !(out_read_done && out_tare_done), "two dones")
  // Timeout is reported only on a finishing tick, which leaves the block idle.
  `ASSERT_IMPL(a_status_done, clk, rst_n, out_valid && out_status,
               (out_read_done || out_tare_done) && !out_busy_res, "stray status")

endmodule
